>>> hw/rtl/ps2mct_pkg.sv
// Package for the PS/2 mouse cursor tracker: header bit positions, packet
// byte states, register indexes and reset extents.
// No dependencies.
`timescale 1ns / 1ps

package ps2mct_pkg;

    // Header byte bit positions
    localparam int unsigned SYNC_BIT   = 3;
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;
    localparam int unsigned BTN_W      = 3;

    // Field widths
    localparam int unsigned RX_W    = 8;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned DELTA_W = RX_W + 1;
    localparam int unsigned SUM_W   = COORD_W + 2;
    localparam int unsigned OUT_W   = 2 * COORD_W + BTN_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = COORD_W;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = 16'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 16'd480;

    // Next packet byte to expect
    typedef enum logic [2:0] {
        POS_HEADER = 3'b001,
        POS_DX     = 3'b010,
        POS_DY     = 3'b100
    } byte_pos_t;

endpackage

>>> hw/rtl/ps2_mouse_cursor_tracker_core.sv
// Top level of the PS/2 mouse cursor tracker: packet assembly, cursor
// update with clamping, and the result register.
// Depends on ps2mct_pkg.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata[7:0] rx_byte
//  m_      | out       | m_tvalid/m_tready  | m_tdata pos_x, pos_y, button_bits
//  cfg_    | in        | cfg_wr_en          | cfg_addr, cfg_wr_data
//
// One byte is accepted per cycle while no third byte is held. A byte goes into
// the input register and from there updates the packet state; a third byte
// loads the cursor registers, which drive m_tdata. Header and X bytes leave
// the input register on the next edge regardless of the output; a third byte
// leaves it only while the result register is empty or being taken, so bytes
// keep flowing while a result waits unless a third byte is held.
// Synchronous active-low reset clears the packet state and cursor and sets the
// extents to 640 by 480.

module ps2_mouse_cursor_tracker_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [7:0] rx_byte
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ps2mct_pkg::RX_W-1:0]          s_tdata,
    // m_tdata: [15:0] pos_x, [31:16] pos_y, [34:32] button_bits, rest zero
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ps2mct_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [ps2mct_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ps2mct_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import ps2mct_pkg::*;

    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;

    logic               in_valid_reg;
    logic [RX_W-1:0]    in_byte_reg;

    byte_pos_t          pos_reg, pos_next;
    logic [RX_W-1:0]    header_reg;
    logic [RX_W-1:0]    delta_x_reg;
    logic [COORD_W-1:0] cursor_col_reg, cursor_col_next;
    logic [COORD_W-1:0] cursor_row_reg, cursor_row_next;
    logic [BTN_W-1:0]   buttons_reg;
    logic               m_valid_reg;

    logic               out_free;
    logic               completes;
    logic               advance;
    logic               load_result;

    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [COORD_W:0]   limit_x;
    logic [COORD_W:0]   limit_y;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wr_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Flow control: only a completing byte needs room in the result register
    assign out_free    = !m_valid_reg || m_tready;
    assign completes   = (pos_reg == POS_DY);
    assign advance     = in_valid_reg && (!completes || out_free);
    assign load_result = advance && completes;
    assign s_tready    = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Signed deltas and moved coordinates
    assign dx = {header_reg[X_SIGN_BIT], delta_x_reg};
    assign dy = {header_reg[Y_SIGN_BIT], in_byte_reg};
    assign sum_x = {2'b00, cursor_col_reg}
                 + {{(SUM_W-DELTA_W){dx[DELTA_W-1]}}, dx};
    assign sum_y = {2'b00, cursor_row_reg}
                 - {{(SUM_W-DELTA_W){dy[DELTA_W-1]}}, dy};

    // An extent of zero acts as one
    assign limit_x = (width_reg == '0)  ? (COORD_W+1)'(1) : {1'b0, width_reg};
    assign limit_y = (height_reg == '0) ? (COORD_W+1)'(1) : {1'b0, height_reg};

    // Clamp to 0 .. extent-1
    always_comb begin
        priority if (sum_x[SUM_W-1]) begin
            cursor_col_next = '0;
        end else if (sum_x[COORD_W:0] >= limit_x) begin
            cursor_col_next = limit_x[COORD_W-1:0] - COORD_W'(1);
        end else begin
            cursor_col_next = sum_x[COORD_W-1:0];
        end
        priority if (sum_y[SUM_W-1]) begin
            cursor_row_next = '0;
        end else if (sum_y[COORD_W:0] >= limit_y) begin
            cursor_row_next = limit_y[COORD_W-1:0] - COORD_W'(1);
        end else begin
            cursor_row_next = sum_y[COORD_W-1:0];
        end
    end

    // Packet byte sequencing; drop unsynced first bytes
    always_comb begin
        pos_next = pos_reg;
        unique case (pos_reg)
            POS_HEADER: if (in_byte_reg[SYNC_BIT]) pos_next = POS_DX;
            POS_DX:     pos_next = POS_DY;
            POS_DY:     pos_next = POS_HEADER;
            default:    pos_next = POS_HEADER;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HEADER;
        end else if (advance) begin
            pos_reg <= pos_next;
        end
    end

    // Hold header and X byte of the packet in progress
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= '0;
            delta_x_reg <= '0;
        end else if (advance) begin
            if (pos_reg == POS_HEADER && in_byte_reg[SYNC_BIT]) begin
                header_reg <= in_byte_reg;
            end
            if (pos_reg == POS_DX) begin
                delta_x_reg <= in_byte_reg;
            end
        end
    end

    // Cursor and buttons double as the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            buttons_reg    <= '0;
        end else if (load_result) begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            buttons_reg    <= header_reg[BTN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-OUT_W)'(0), buttons_reg, cursor_row_reg, cursor_col_reg};

`ifndef SYNTH
    // A completed packet always shows a result on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> m_valid_reg)
        else $error("completed packet produced no result");

    // A third byte never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !load_result)
        else $error("pending result overwritten");

    // A completed packet returns the sequencer to the header byte
    a_back_to_header: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> (pos_reg == POS_HEADER))
        else $error("sequencer did not return to header");

    // A held byte stays in the input register
    a_hold_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held byte lost");

    // The cursor moves only together with a new result
    a_cursor_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_result |=> ($stable(cursor_col_reg) && $stable(cursor_row_reg)))
        else $error("cursor changed without a result");
`endif

endmodule
